// File: sv/hd44780_nibble_sequencer_defines.svh
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef HD44780_NIBBLE_SEQUENCER_DEFINES_SVH
`define HD44780_NIBBLE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdns: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HDNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdns: next-cycle check failed");

`endif

// File: sv/hdns_pkg.sv
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer package
// Field widths, operation and register codes, microcode format and program.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdns_pkg;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 2;
   localparam int NIB_W    = 4;
   localparam int WAIT_W   = 16;
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CMD    = 2'd1;
   localparam logic [OP_W-1:0] OP_DATA   = 2'd2;
   localparam logic [OP_W-1:0] OP_CURSOR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TWO_LINES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WAIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WAIT = 2'd2;

   localparam logic [WAIT_W-1:0] LONG_WAIT_RESET  = 16'd1600;
   localparam logic [WAIT_W-1:0] SHORT_WAIT_RESET = 16'd43;
   localparam logic [WAIT_W-1:0] POWER_UP_WAIT    = 16'd15000;
   localparam logic [WAIT_W-1:0] FIRST_RESET_WAIT = 16'd4100;
   localparam logic [WAIT_W-1:0] RESET_WAIT       = 16'd120;

   localparam logic [BYTE_W-1:0] CMD_FUNC_TWO  = 8'h28;
   localparam logic [BYTE_W-1:0] CMD_FUNC_ONE  = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY   = 8'h0C;
   localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;

   localparam logic [STEP_W-1:0] STEP_INIT = 4'd0;
   localparam logic [STEP_W-1:0] STEP_BYTE = 4'd13;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd14;

   typedef enum logic [1:0] {
      NSRC_CONST = 2'd0,
      NSRC_HIGH  = 2'd1,
      NSRC_LOW   = 2'd2
   } nsrc_type;

   typedef enum logic [2:0] {
      WSRC_ZERO  = 3'd0,
      WSRC_POWER = 3'd1,
      WSRC_FIRST = 3'd2,
      WSRC_RESET = 3'd3,
      WSRC_BYTE  = 3'd4
   } wsrc_type;

   typedef enum logic [2:0] {
      BSRC_FUNC    = 3'd0,
      BSRC_CLEAR   = 3'd1,
      BSRC_ENTRY   = 3'd2,
      BSRC_DISPLAY = 3'd3,
      BSRC_REQ     = 3'd4
   } bsrc_type;

   typedef struct packed {
      logic             strobe;
      nsrc_type         nsrc;
      logic [NIB_W-1:0] const_nib;
      wsrc_type         wsrc;
      bsrc_type         bsrc;
      logic             last;
   } cw_type;

   typedef struct packed {
      logic   accept;
      logic   load;
      cw_type cw;
   } ctrl_type;

   function automatic cw_type mk_cw(input logic strobe, input nsrc_type nsrc,
                                    input logic [NIB_W-1:0] nib, input wsrc_type wsrc,
                                    input bsrc_type bsrc, input logic last);
      cw_type w;
      w.strobe    = strobe;
      w.nsrc      = nsrc;
      w.const_nib = nib;
      w.wsrc      = wsrc;
      w.bsrc      = bsrc;
      w.last      = last;
      return w;
   endfunction

   // Microcode program. Initialization starts at step 0, single bytes at step 13.
   function automatic cw_type hdns_ucode(input logic [STEP_W-1:0] step);
      cw_type w;
      unique case (step)
         4'd0:    w = mk_cw(1'b0, NSRC_CONST, 4'h0, WSRC_POWER, BSRC_REQ, 1'b0);
         4'd1:    w = mk_cw(1'b1, NSRC_CONST, 4'h3, WSRC_FIRST, BSRC_REQ, 1'b0);
         4'd2:    w = mk_cw(1'b1, NSRC_CONST, 4'h3, WSRC_RESET, BSRC_REQ, 1'b0);
         4'd3:    w = mk_cw(1'b1, NSRC_CONST, 4'h3, WSRC_RESET, BSRC_REQ, 1'b0);
         4'd4:    w = mk_cw(1'b1, NSRC_CONST, 4'h2, WSRC_RESET, BSRC_REQ, 1'b0);
         4'd5:    w = mk_cw(1'b1, NSRC_HIGH, 4'h0, WSRC_ZERO, BSRC_FUNC, 1'b0);
         4'd6:    w = mk_cw(1'b1, NSRC_LOW, 4'h0, WSRC_BYTE, BSRC_FUNC, 1'b0);
         4'd7:    w = mk_cw(1'b1, NSRC_HIGH, 4'h0, WSRC_ZERO, BSRC_CLEAR, 1'b0);
         4'd8:    w = mk_cw(1'b1, NSRC_LOW, 4'h0, WSRC_BYTE, BSRC_CLEAR, 1'b0);
         4'd9:    w = mk_cw(1'b1, NSRC_HIGH, 4'h0, WSRC_ZERO, BSRC_ENTRY, 1'b0);
         4'd10:   w = mk_cw(1'b1, NSRC_LOW, 4'h0, WSRC_BYTE, BSRC_ENTRY, 1'b0);
         4'd11:   w = mk_cw(1'b1, NSRC_HIGH, 4'h0, WSRC_ZERO, BSRC_DISPLAY, 1'b0);
         4'd12:   w = mk_cw(1'b1, NSRC_LOW, 4'h0, WSRC_BYTE, BSRC_DISPLAY, 1'b1);
         4'd13:   w = mk_cw(1'b1, NSRC_HIGH, 4'h0, WSRC_ZERO, BSRC_REQ, 1'b0);
         4'd14:   w = mk_cw(1'b1, NSRC_LOW, 4'h0, WSRC_BYTE, BSRC_REQ, 1'b1);
         default: w = mk_cw(1'b0, NSRC_CONST, 4'h0, WSRC_ZERO, BSRC_REQ, 1'b1);
      endcase
      return w;
   endfunction

   function automatic logic [BYTE_W-1:0] row_offset(input logic [ROW_W-1:0] row);
      logic [BYTE_W-1:0] offs;
      unique case (row)
         2'd0:    offs = 8'd0;
         2'd1:    offs = 8'd64;
         2'd2:    offs = 8'd20;
         default: offs = 8'd84;
      endcase
      return offs;
   endfunction

endpackage

`default_nettype wire

// File: sv/hdns_if.sv
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer channels
// Request and response channel interfaces with valid/ready handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hdns_req_if import hdns_pkg::*;;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] byte_value;
   logic [COL_W-1:0]  column;
   logic [ROW_W-1:0]  row;

   modport source (output valid, output operation, output byte_value,
                   output column, output row, input ready);
   modport sink (input valid, input operation, input byte_value,
                 input column, input row, output ready);
endinterface

interface hdns_rsp_if import hdns_pkg::*;;
   logic              valid;
   logic              ready;
   logic              strobe_res;
   logic              register_select;
   logic [NIB_W-1:0]  nibble;
   logic [WAIT_W-1:0] wait_us;
   logic              last;

   modport source (output valid, output strobe_res, output register_select,
                   output nibble, output wait_us, output last, input ready);
   modport sink (input valid, input strobe_res, input register_select,
                 input nibble, input wait_us, input last, output ready);
endinterface

`default_nettype wire

// File: sv/hdns_sequencer.sv
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer control
// Step counter, microcode fetch, entry dispatch and output handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hd44780_nibble_sequencer_defines.svh"

module hdns_sequencer import hdns_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 req_ready,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   output ctrl_type             ctrl
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   cw_type            cw;
   logic              load;
   logic              finish;
   logic              accept;
   logic [STEP_W-1:0] entry;

   always_comb begin
      cw     = hdns_ucode(step_ff);
      load   = busy_ff && (!valid_ff || rsp_ready);
      finish = load && cw.last;
      req_ready = !busy_ff || finish;
      accept = req_valid && req_ready;
      entry  = (req_operation == OP_INIT) ? STEP_INIT : STEP_BYTE;

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end

      step_in = step_ff;
      if (accept) begin
         step_in = entry;
      end else if (load) begin
         step_in = step_ff + 4'd1;
      end

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= STEP_INIT;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign ctrl.accept = accept;
   assign ctrl.load   = load;
   assign ctrl.cw     = cw;

   `HDNS_ASSERT_NEXT(a_accept_starts, clock, reset, accept, busy_ff)
   `HDNS_ASSERT_IMPLY(a_step_in_program, clock, reset, busy_ff, step_ff <= STEP_LAST)
   `HDNS_ASSERT_NEXT(a_step_advances, clock, reset, load && !cw.last,
                     busy_ff && step_ff == $past(step_ff) + 4'd1)
   `HDNS_ASSERT_NEXT(a_step_holds, clock, reset, busy_ff && !load,
                     busy_ff && $stable(step_ff))

endmodule

`default_nettype wire

// File: sv/hdns_datapath.sv
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer datapath
// Control registers, request byte capture, operand selection and the
// response register loaded under microcode control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdns_datapath import hdns_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_type             ctrl,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WAIT_W-1:0]    csr_write_data,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [BYTE_W-1:0]    req_byte_value,
   input  wire logic [COL_W-1:0]     req_column,
   input  wire logic [ROW_W-1:0]     req_row,
   output logic                      rsp_strobe_res,
   output logic                      rsp_register_select,
   output logic [NIB_W-1:0]          rsp_nibble,
   output logic [WAIT_W-1:0]         rsp_wait_us,
   output logic                      rsp_last
);

   logic              two_lines_ff;
   logic [WAIT_W-1:0] long_wait_ff;
   logic [WAIT_W-1:0] short_wait_ff;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              rs_ff, rs_in;
   logic [BYTE_W-1:0] cur_byte;
   logic              use_long;
   logic [NIB_W-1:0]  nib_in;
   logic [WAIT_W-1:0] wait_in;
   logic              strobe_ff;
   logic              sel_ff;
   logic [NIB_W-1:0]  nib_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_lines_ff  <= 1'b1;
         long_wait_ff  <= LONG_WAIT_RESET;
         short_wait_ff <= SHORT_WAIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TWO_LINES:  two_lines_ff  <= csr_write_data[0];
            CSR_LONG_WAIT:  long_wait_ff  <= csr_write_data;
            CSR_SHORT_WAIT: short_wait_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_operation == OP_CURSOR) begin
         byte_in = (row_offset(req_row) + {2'b00, req_column}) | CMD_SET_DDRAM;
      end else begin
         byte_in = req_byte_value;
      end
      rs_in = (req_operation == OP_DATA);

      unique case (ctrl.cw.bsrc)
         BSRC_FUNC:    cur_byte = two_lines_ff ? CMD_FUNC_TWO : CMD_FUNC_ONE;
         BSRC_CLEAR:   cur_byte = CMD_CLEAR;
         BSRC_ENTRY:   cur_byte = CMD_ENTRY;
         BSRC_DISPLAY: cur_byte = CMD_DISPLAY;
         default:      cur_byte = byte_ff;
      endcase

      use_long = !rs_ff && (cur_byte[BYTE_W-1:2] == '0);

      unique case (ctrl.cw.nsrc)
         NSRC_HIGH: nib_in = cur_byte[BYTE_W-1:NIB_W];
         NSRC_LOW:  nib_in = cur_byte[NIB_W-1:0];
         default:   nib_in = ctrl.cw.const_nib;
      endcase

      unique case (ctrl.cw.wsrc)
         WSRC_POWER: wait_in = POWER_UP_WAIT;
         WSRC_FIRST: wait_in = FIRST_RESET_WAIT;
         WSRC_RESET: wait_in = RESET_WAIT;
         WSRC_BYTE:  wait_in = use_long ? long_wait_ff : short_wait_ff;
         default:    wait_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         byte_ff <= byte_in;
         rs_ff   <= rs_in;
      end
      if (ctrl.load) begin
         strobe_ff <= ctrl.cw.strobe;
         sel_ff    <= rs_ff;
         nib_ff    <= nib_in;
         wait_ff   <= wait_in;
         last_ff   <= ctrl.cw.last;
      end
   end

   assign rsp_strobe_res      = strobe_ff;
   assign rsp_register_select = sel_ff;
   assign rsp_nibble          = nib_ff;
   assign rsp_wait_us         = wait_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire

// File: sv/hd44780_nibble_sequencer.sv
// ---------------------------------------------------------------------------
// HD44780 nibble sequencer
// Turns LCD requests into 4-bit bus transfers and waits for an HD44780
// controller, driven by a microcoded step sequencer.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   req_chan  in         operation, byte_value, column, row
//   rsp_chan  out        strobe_res, register_select, nibble, wait_us, last
//   csr_*     in         write enable, register index, 16-bit write data
//
// One response transfer leaves per cycle while the sink is ready: two for a
// command, data or cursor request and thirteen for initialization, set by the
// step counter walking the microcode.
// The next request is taken in the cycle that loads the last response.
// Reset clears the sequencer and restores the register defaults.
// A stalled response holds in the output register and the step counter waits.
//
`timescale 1ns / 1ps
`default_nettype none

module hd44780_nibble_sequencer import hdns_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   hdns_req_if.sink                  req_chan,
   hdns_rsp_if.source                rsp_chan,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WAIT_W-1:0]    csr_write_data
);

   ctrl_type ctrl;

   hdns_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .ctrl          (ctrl)
   );

   hdns_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_chan.operation),
      .req_byte_value      (req_chan.byte_value),
      .req_column          (req_chan.column),
      .req_row             (req_chan.row),
      .rsp_strobe_res      (rsp_chan.strobe_res),
      .rsp_register_select (rsp_chan.register_select),
      .rsp_nibble          (rsp_chan.nibble),
      .rsp_wait_us         (rsp_chan.wait_us),
      .rsp_last            (rsp_chan.last)
   );

endmodule

`default_nettype wire
